[rtl/fvt_pkg.sv]
// constants, types and plane field helpers for the frustum visibility test
package fvt_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;
    localparam int RADIUS_BITS      = COORD_BITS - 1;
    localparam int PLANE_COUNT      = 6;
    localparam int AXIS_COUNT       = 3;
    localparam int PLANE_BITS       = 64;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int PROD_BITS        = NORMAL_BITS + COORD_BITS;
    localparam int DTERM_BITS       = COORD_BITS + NORMAL_FRAC_BITS;
    localparam int LIMIT_BITS       = RADIUS_BITS + NORMAL_FRAC_BITS + 1;
    localparam int SUM_BITS         = PROD_BITS + 2;
    localparam int IN_DATA_BITS     = ((6 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS    = 8;
    localparam int OP_BITS          = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_POINT  = 2'd0,
        OP_SPHERE = 2'd1,
        OP_BOX    = 2'd2
    } op_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [NORMAL_BITS-1:0] normal_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [DTERM_BITS-1:0] dterm_t;
    typedef logic signed [LIMIT_BITS-1:0] limit_t;
    typedef logic signed [SUM_BITS-1:0] sum_t;
    typedef logic [PLANE_BITS-1:0] plane_t;

    // normal component of a plane register, slot 0..2 for x, y, z
    function automatic normal_t plane_normal(input plane_t plane, input int slot);
        return normal_t'(plane[slot*NORMAL_BITS +: NORMAL_BITS]);
    endfunction

    // distance term d * 2^frac, exact
    function automatic dterm_t plane_dterm(input plane_t plane);
        coord_t d;
        d = coord_t'(plane[AXIS_COUNT*NORMAL_BITS +: COORD_BITS]);
        return dterm_t'({d, {NORMAL_FRAC_BITS{1'b0}}});
    endfunction

endpackage

[rtl/frustum_visibility_test.sv]
// six-plane frustum culling of a point, sphere or box, four-stage pipeline
//
//  channel | direction | payload                                      | handshake
//  --------+-----------+----------------------------------------------+---------------------
//  s_axis  | in        | tdata: min xyz, max xyz, radius; tuser: op   | tvalid / tready
//  m_axis  | out       | tdata: visible                               | tvalid / tready
//  cfg     | in        | cfg_index (plane), cfg_data (packed plane)   | cfg_valid / cfg_ready
//
// one request per cycle while m_axis does not stall; a request passes through the stage 1, 2, 3 and output registers
// stages: p-vertex select, 18 products, per-plane sum and compare, reject merge
// each stage holds its own valid bit, so bubbles close up under a stall
// rst_n clears the planes and all valid bits; cfg is always ready
module frustum_visibility_test
    import fvt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, radius, zero fill
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    // opcode
    input  logic [OP_BITS-1:0]        s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // visible, zero fill
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PLANE_BITS-1:0]     cfg_data
);

    plane_t plane_reg [PLANE_COUNT];

    // stage 1: selected vertex per plane, sphere limit
    logic   s1_valid_reg;
    coord_t s1_coord_reg [PLANE_COUNT][AXIS_COUNT];
    coord_t s1_coord_next [PLANE_COUNT][AXIS_COUNT];
    limit_t s1_limit_reg, s1_limit_next;
    logic   s1_test_reg, s1_test_next;

    // stage 2: products
    logic   s2_valid_reg;
    prod_t  s2_prod_reg [PLANE_COUNT][AXIS_COUNT];
    prod_t  s2_prod_next [PLANE_COUNT][AXIS_COUNT];
    dterm_t s2_dterm_reg [PLANE_COUNT];
    limit_t s2_limit_reg;
    logic   s2_test_reg;

    // stage 3: per-plane reject
    logic                   s3_valid_reg;
    logic [PLANE_COUNT-1:0] s3_reject_reg, s3_reject_next;
    logic                   s3_test_reg;

    // stage 4: output
    logic out_valid_reg;
    logic visible_reg, visible_next;

    logic ready1, ready2, ready3, ready4;

    op_t    op;
    coord_t in_min [AXIS_COUNT];
    coord_t in_max [AXIS_COUNT];
    logic [RADIUS_BITS-1:0] in_radius;

    assign ready4 = !out_valid_reg || m_axis_tready;
    assign ready3 = !s3_valid_reg || ready4;
    assign ready2 = !s2_valid_reg || ready3;
    assign ready1 = !s1_valid_reg || ready2;

    assign s_axis_tready = ready1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-1){1'b0}}, visible_reg};
    assign cfg_ready     = 1'b1;

    assign op        = op_t'(s_axis_tuser);
    assign in_radius = s_axis_tdata[6*COORD_BITS +: RADIUS_BITS];

    always_comb
    begin
        for (int a = 0; a < AXIS_COUNT; a++)
        begin
            in_min[a] = coord_t'(s_axis_tdata[a*COORD_BITS +: COORD_BITS]);
            in_max[a] = coord_t'(s_axis_tdata[(a+AXIS_COUNT)*COORD_BITS +: COORD_BITS]);
        end
    end

    // p-vertex: max on axes with a positive normal component, box only; also the sphere limit and the test bit
    always_comb
    begin
        s1_limit_next = '0;
        s1_test_next  = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                s1_coord_next[p][a] = in_min[a];
            end
        end
        case (op)
            OP_POINT:
            begin
                s1_test_next = 1'b1;
            end
            OP_SPHERE:
            begin
                s1_limit_next = -limit_t'({1'b0, in_radius, {NORMAL_FRAC_BITS{1'b0}}});
            end
            OP_BOX:
            begin
                for (int p = 0; p < PLANE_COUNT; p++)
                begin
                    for (int a = 0; a < AXIS_COUNT; a++)
                    begin
                        if (plane_normal(plane_reg[p], a) > 0)
                        begin
                            s1_coord_next[p][a] = in_max[a];
                        end
                    end
                end
            end
            default:
            begin
                s1_test_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                s2_prod_next[p][a] = plane_normal(plane_reg[p], a) * s1_coord_reg[p][a];
            end
        end
    end

    always_comb
    begin
        sum_t dist_sum;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            dist_sum = sum_t'(s2_prod_reg[p][0]) + sum_t'(s2_prod_reg[p][1])
                     + sum_t'(s2_prod_reg[p][2]) + sum_t'(s2_dterm_reg[p]);
            s3_reject_next[p] = dist_sum < sum_t'(s2_limit_reg);
        end
    end

    assign visible_next = !s3_test_reg || !(|s3_reject_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                plane_reg[p] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready && (int'(cfg_index) < PLANE_COUNT))
        begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ready4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && s_axis_tvalid)
        begin
            s1_coord_reg <= s1_coord_next;
            s1_limit_reg <= s1_limit_next;
            s1_test_reg  <= s1_test_next;
        end
        if (ready2 && s1_valid_reg)
        begin
            s2_prod_reg  <= s2_prod_next;
            s2_limit_reg <= s1_limit_reg;
            s2_test_reg  <= s1_test_reg;
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                s2_dterm_reg[p] <= plane_dterm(plane_reg[p]);
            end
        end
        if (ready3 && s2_valid_reg)
        begin
            s3_reject_reg <= s3_reject_next;
            s3_test_reg   <= s2_test_reg;
        end
        if (ready4 && s3_valid_reg)
        begin
            visible_reg <= visible_next;
        end
    end

endmodule
